// File: hdl/ps_pkg.sv
// Shared types and constants of the power-off supervisor.
package ps_pkg;

  // Width of the millisecond time base; elapsed times wrap at this width.
  localparam int TICK_BITS = 32;

  typedef enum logic [1:0] {
    OP_TASK  = 2'd0,
    OP_LINK  = 2'd1,
    OP_PRESS = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_BATTERY_INTERVAL = 3'd0;
  localparam logic [2:0] REG_CRITICAL_PERCENT = 3'd1;
  localparam logic [2:0] REG_LOW_PERCENT      = 3'd2;
  localparam logic [2:0] REG_AUTO_OFF_DELAY   = 3'd3;
  localparam logic [2:0] REG_HOLD_OFF_DELAY   = 3'd4;

  localparam logic [31:0] RST_BATTERY_INTERVAL = 32'd1000;
  localparam logic [6:0]  RST_CRITICAL_PERCENT = 7'd5;
  localparam logic [6:0]  RST_LOW_PERCENT      = 7'd15;
  localparam logic [31:0] RST_AUTO_OFF_DELAY   = 32'd300000;
  localparam logic [31:0] RST_HOLD_OFF_DELAY   = 32'd2000;

  typedef struct packed {
    op_t         operation;
    logic [31:0] now_ms;
    logic [6:0]  battery_percent;
    logic        button_held;
    logic        link_connected;
  } req_t;

  typedef struct packed {
    logic power_enable;
    logic status_led;
    logic charge_low;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } cfg_t;

endpackage

// File: hdl/ps_if.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
interface ps_req_if;
  logic           valid;
  logic           ready;
  ps_pkg::req_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ps_rsp_if;
  logic           valid;
  logic           ready;
  ps_pkg::rsp_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ps_cfg_if;
  logic           valid;
  logic           ready;
  ps_pkg::cfg_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/power_off_supervisor.sv
// Top level of the power-off supervisor: request register, state update, result register.
//
// Usage: requests arrive on req (operation, now_ms, battery_percent, button_held,
// link_connected). Operation task step samples the battery when the check interval
// has run out, checks the auto-off and hold-off timers and drives the LED; a link
// request records the link state; a press request records the press time.
// Every request gives exactly one result on rsp: power_enable, status_led and
// charge_low as they stand after that request.
// A result follows its request through the request register, then the result register,
// so its handshake always comes on a later edge than the request handshake.
// Throughput is one request per cycle while the receiver takes results, set by the single
// state update between the request register and the result register.
// Configuration writes on cfg are always taken (ready stays high) and must only be
// issued while no request is in flight. Indexes beyond the register list are ignored.
// Reset (rst, synchronous) loads the register defaults, clears all times and flags,
// and sets the power latch on. Once power_enable drops it stays low until reset.
// When the receiver stalls, the result register holds, the request register holds
// behind it, and req.ready falls only once both are full.
module power_off_supervisor (
  input  logic      clk,
  input  logic      rst,
  ps_req_if.sink    req,
  ps_rsp_if.source  rsp,
  ps_cfg_if.sink    cfg
);

  localparam int TB = ps_pkg::TICK_BITS;

  // Configuration registers.
  logic [31:0] battery_interval;
  logic [6:0]  critical_percent;
  logic [6:0]  low_percent;
  logic [31:0] auto_off_delay;
  logic [31:0] hold_off_delay;

  // Supervisor state.
  logic [TB-1:0] last_battery_time, last_battery_time_next;
  logic [TB-1:0] last_disconnect_time, last_disconnect_time_next;
  logic [TB-1:0] last_press_time, last_press_time_next;
  logic          is_connected, is_connected_next;
  logic          low_flag, low_flag_next;
  logic          led_level, led_level_next;
  logic          power_latch, power_latch_next;

  // Request register.
  logic          s1_valid;
  ps_pkg::req_t  s1;
  logic          advance;

  logic [TB-1:0] now_tick;
  logic [TB-1:0] since_battery, since_disconnect, since_press;

  assign cfg.ready = 1'b1;

  assign advance   = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_interval <= ps_pkg::RST_BATTERY_INTERVAL;
      critical_percent <= ps_pkg::RST_CRITICAL_PERCENT;
      low_percent      <= ps_pkg::RST_LOW_PERCENT;
      auto_off_delay   <= ps_pkg::RST_AUTO_OFF_DELAY;
      hold_off_delay   <= ps_pkg::RST_HOLD_OFF_DELAY;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        ps_pkg::REG_BATTERY_INTERVAL: battery_interval <= cfg.data.value;
        ps_pkg::REG_CRITICAL_PERCENT: critical_percent <= cfg.data.value[6:0];
        ps_pkg::REG_LOW_PERCENT:      low_percent      <= cfg.data.value[6:0];
        ps_pkg::REG_AUTO_OFF_DELAY:   auto_off_delay   <= cfg.data.value;
        ps_pkg::REG_HOLD_OFF_DELAY:   hold_off_delay   <= cfg.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1 <= req.data;
    end
  end

  assign now_tick         = TB'(s1.now_ms);
  assign since_battery    = now_tick - last_battery_time;
  assign since_disconnect = now_tick - last_disconnect_time;
  assign since_press      = now_tick - last_press_time;

  always_comb begin
    last_battery_time_next    = last_battery_time;
    last_disconnect_time_next = last_disconnect_time;
    last_press_time_next      = last_press_time;
    is_connected_next         = is_connected;
    low_flag_next             = low_flag;
    led_level_next            = led_level;
    power_latch_next          = power_latch;
    unique case (s1.operation)
      ps_pkg::OP_TASK: begin
        if (64'(since_battery) >= 64'(battery_interval)) begin
          if (s1.battery_percent <= critical_percent) begin
            power_latch_next = 1'b0;
          end
          low_flag_next          = (s1.battery_percent <= low_percent);
          last_battery_time_next = now_tick;
        end
        if (64'(since_disconnect) >= 64'(auto_off_delay) && !is_connected) begin
          power_latch_next = 1'b0;
        end
        // A long hold wins over the low-battery blink and forces the LED on.
        if (64'(since_press) >= 64'(hold_off_delay) && s1.button_held) begin
          led_level_next   = 1'b1;
          power_latch_next = 1'b0;
        end else if (low_flag_next) begin
          led_level_next = !led_level;
        end else begin
          led_level_next = 1'b0;
        end
      end
      ps_pkg::OP_LINK: begin
        if (!s1.link_connected) begin
          last_disconnect_time_next = now_tick;
        end
        is_connected_next = s1.link_connected;
      end
      ps_pkg::OP_PRESS: begin
        last_press_time_next = now_tick;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_battery_time    <= '0;
      last_disconnect_time <= '0;
      last_press_time      <= '0;
      is_connected         <= 1'b0;
      low_flag             <= 1'b0;
      led_level            <= 1'b0;
      power_latch          <= 1'b1;
    end else if (advance) begin
      last_battery_time    <= last_battery_time_next;
      last_disconnect_time <= last_disconnect_time_next;
      last_press_time      <= last_press_time_next;
      is_connected         <= is_connected_next;
      low_flag             <= low_flag_next;
      led_level            <= led_level_next;
      power_latch          <= power_latch_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.data.power_enable <= power_latch_next;
      rsp.data.status_led   <= led_level_next;
      rsp.data.charge_low   <= low_flag_next;
    end
  end

  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    !power_latch |=> !power_latch)
    else $error("power latch came back on without reset");

  a_latch_falls_on_task: assert property (@(posedge clk) disable iff (rst)
    $fell(power_latch) |-> $past(advance && s1.operation == ps_pkg::OP_TASK))
    else $error("power latch cleared by a request other than a task step");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp.valid && rsp.data.power_enable == power_latch
      && rsp.data.status_led == led_level && rsp.data.charge_low == low_flag)
    else $error("result register disagrees with the updated state");

  a_stalled_request_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1))
    else $error("stalled request register lost its request");

endmodule

// File: tb/sv/supervisor_monitor.sv
// Channel monitor that predicts each status result of the supervisor and compares it.
module supervisor_monitor (
  input  logic clk,
  input  logic rst,
  ps_req_if    req,
  ps_rsp_if    rsp,
  ps_cfg_if    cfg,
  output int   errors,
  output int   outstanding,
  output int   results
);

  logic [31:0] interval_ms;
  logic [6:0]  crit_pct;
  logic [6:0]  low_pct;
  logic [31:0] auto_off_ms;
  logic [31:0] hold_off_ms;

  logic [31:0] batt_stamp;
  logic [31:0] disc_stamp;
  logic [31:0] press_stamp;
  logic        linked;
  logic        low_q;
  logic        led_q;
  logic        power_q;

  ps_pkg::rsp_t want_status[$];
  ps_pkg::rsp_t want;

  // Advances the supervisor state by one request and returns the status it leaves.
  function automatic ps_pkg::rsp_t supervise(ps_pkg::req_t r);
    ps_pkg::rsp_t o;
    case (r.operation)
      ps_pkg::OP_TASK: begin
        if ((r.now_ms - batt_stamp) >= interval_ms) begin
          if (r.battery_percent <= crit_pct) power_q = 1'b0;
          low_q = (r.battery_percent <= low_pct);
          batt_stamp = r.now_ms;
        end
        if (((r.now_ms - disc_stamp) >= auto_off_ms) && !linked) power_q = 1'b0;
        // A long hold lights the LED and skips the blink update.
        if (((r.now_ms - press_stamp) >= hold_off_ms) && r.button_held) begin
          led_q = 1'b1;
          power_q = 1'b0;
        end else begin
          led_q = low_q ? !led_q : 1'b0;
        end
      end
      ps_pkg::OP_LINK: begin
        if (!r.link_connected) disc_stamp = r.now_ms;
        linked = r.link_connected;
      end
      ps_pkg::OP_PRESS: press_stamp = r.now_ms;
      ps_pkg::OP_NONE: ;
    endcase
    o.power_enable = power_q;
    o.status_led   = led_q;
    o.charge_low   = low_q;
    return o;
  endfunction

  task automatic compare_bit(string field, logic exp_bit, logic got_bit);
    if (got_bit !== exp_bit) begin
      $display("%0t: %s mismatch: expected %0b, actual %0b", $time, field, exp_bit, got_bit);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      interval_ms = ps_pkg::RST_BATTERY_INTERVAL;
      crit_pct    = ps_pkg::RST_CRITICAL_PERCENT;
      low_pct     = ps_pkg::RST_LOW_PERCENT;
      auto_off_ms = ps_pkg::RST_AUTO_OFF_DELAY;
      hold_off_ms = ps_pkg::RST_HOLD_OFF_DELAY;
      batt_stamp  = '0;
      disc_stamp  = '0;
      press_stamp = '0;
      linked      = 1'b0;
      low_q       = 1'b0;
      led_q       = 1'b0;
      power_q     = 1'b1;
      want_status.delete();
      errors  = 0;
      results = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results++;
        if (want_status.size() == 0) begin
          $display("%0t: unexpected status result: expected none, actual %b", $time, rsp.data);
          errors++;
        end else begin
          want = want_status.pop_front();
          compare_bit("power_enable", want.power_enable, rsp.data.power_enable);
          compare_bit("status_led", want.status_led, rsp.data.status_led);
          compare_bit("charge_low", want.charge_low, rsp.data.charge_low);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.index)
          ps_pkg::REG_BATTERY_INTERVAL: interval_ms = cfg.data.value;
          ps_pkg::REG_CRITICAL_PERCENT: crit_pct    = cfg.data.value[6:0];
          ps_pkg::REG_LOW_PERCENT:      low_pct     = cfg.data.value[6:0];
          ps_pkg::REG_AUTO_OFF_DELAY:   auto_off_ms = cfg.data.value;
          ps_pkg::REG_HOLD_OFF_DELAY:   hold_off_ms = cfg.data.value;
          default: ;
        endcase
      end
      if (req.valid && req.ready) want_status.push_back(supervise(req.data));
    end
    outstanding <= want_status.size();
  end

endmodule

// File: tb/sv/tb_power_off_supervisor.sv
// Top of the power-off supervisor testbench: clock, reset, stimulus and verdict.
module tb_power_off_supervisor;

  typedef enum logic [1:0] {
    CUT_BATTERY = 2'd0,
    CUT_LINK    = 2'd1,
    CUT_HOLD    = 2'd2
  } cut_t;

  localparam logic [2:0] KEEP_ALL    = 3'b111;
  localparam logic [2:0] KEEP_NONE   = 3'b000;
  localparam logic [2:0] REG_UNUSED  = 3'd7;
  localparam int         QUIET_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst;

  int mismatches;
  int in_flight;
  int results_seen;
  int requests_sent;
  int reg_writes;
  int quiet;
  bit steady;

  logic [31:0] tick;
  logic [31:0] press_tick;
  logic [31:0] disc_tick;
  logic        link_up;
  logic [31:0] cur_interval;
  logic [6:0]  cur_crit;
  logic [6:0]  cur_low;
  logic [31:0] cur_auto;
  logic [31:0] cur_hold;
  cut_t        cause;
  logic [2:0]  final_keep;

  ps_req_if req ();
  ps_rsp_if rsp ();
  ps_cfg_if cfg ();

  power_off_supervisor u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  supervisor_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg         (cfg),
    .errors      (mismatches),
    .outstanding (in_flight),
    .results     (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp.ready <= steady || ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a handshake", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Sends one request and keeps track of the press, link and disconnect history.
  task automatic put(ps_pkg::op_t op, logic [31:0] now, logic [6:0] soc, logic held,
                     logic link);
    if (!steady)
      while ($urandom_range(99) < 17) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    req.valid <= 1'b1;
    req.data  <= '{op, now, soc, held, link};
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    requests_sent++;
    if (op == ps_pkg::OP_PRESS) press_tick = now;
    if (op == ps_pkg::OP_LINK) begin
      link_up = link;
      if (!link) disc_tick = now;
    end
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] interval, logic [6:0] crit, logic [6:0] low,
                              logic [31:0] auto_off, logic [31:0] hold, bit junk);
    ps_pkg::cfg_t writes[$];
    if (junk) writes.push_back('{REG_UNUSED, $urandom()});
    writes.push_back('{ps_pkg::REG_BATTERY_INTERVAL, interval});
    // Upper bits of the percent registers are noise that must be dropped.
    writes.push_back('{ps_pkg::REG_CRITICAL_PERCENT, ($urandom() & 32'hFFFF_FF80) | crit});
    writes.push_back('{ps_pkg::REG_LOW_PERCENT, ($urandom() & 32'hFFFF_FF80) | low});
    writes.push_back('{ps_pkg::REG_AUTO_OFF_DELAY, auto_off});
    writes.push_back('{ps_pkg::REG_HOLD_OFF_DELAY, hold});
    foreach (writes[i]) begin
      cfg.valid <= 1'b1;
      cfg.data  <= writes[i];
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
    end
    cfg.valid <= 1'b0;
    reg_writes += writes.size();
    cur_interval = interval;
    cur_crit     = crit;
    cur_low      = low;
    cur_auto     = auto_off;
    cur_hold     = hold;
  endtask

  // Random requests on an advancing clock. Causes of a power cut whose bit is set in
  // keep are steered away from, so the latch stays on and the rest stays visible.
  task automatic random_items(int count, int step_max, logic [2:0] keep);
    ps_pkg::op_t op;
    logic [31:0] now;
    logic [6:0]  soc;
    logic        held;
    logic        link;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 70) op = ps_pkg::OP_TASK;
      else if (pick < 82) op = ps_pkg::OP_LINK;
      else if (pick < 96) op = ps_pkg::OP_PRESS;
      else op = ps_pkg::OP_NONE;
      if ($urandom_range(9) == 0) begin
        now = $urandom();
      end else begin
        tick += $urandom_range(step_max);
        now = tick;
      end
      case ($urandom_range(2))
        0: soc = 7'($urandom_range(127));
        1: soc = cur_low + 7'($urandom_range(4)) - 7'd2;
        default: soc = cur_crit + 7'($urandom_range(4)) - 7'd2;
      endcase
      held = 1'($urandom_range(1));
      link = 1'($urandom_range(1));
      if (op == ps_pkg::OP_TASK) begin
        if (keep[CUT_BATTERY] && soc <= cur_crit)
          soc = 7'($urandom_range(127, int'(cur_crit) + 1));
        if (keep[CUT_HOLD] && held && (now - press_tick) >= cur_hold) held = 1'b0;
        if (keep[CUT_LINK] && !link_up && (now - disc_tick) >= cur_auto) begin
          op = ps_pkg::OP_LINK;
          link = 1'b1;
        end
      end
      put(op, now, soc, held, link);
    end
  endtask

  initial begin
    req.valid <= 1'b0;
    req.data  <= '0;
    cfg.valid <= 1'b0;
    cfg.data  <= '0;
    rst       <= 1'b1;
    steady        = 1'b0;
    tick          = '0;
    press_tick    = '0;
    disc_tick     = '0;
    link_up       = 1'b0;
    requests_sent = 0;
    reg_writes    = 0;
    cur_interval  = ps_pkg::RST_BATTERY_INTERVAL;
    cur_crit      = ps_pkg::RST_CRITICAL_PERCENT;
    cur_low       = ps_pkg::RST_LOW_PERCENT;
    cur_auto      = ps_pkg::RST_AUTO_OFF_DELAY;
    cur_hold      = ps_pkg::RST_HOLD_OFF_DELAY;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: thresholds and timer boundaries hit exactly and one short of.
    put(ps_pkg::OP_NONE, 32'hFFFF_FFFF, 7'd127, 1'b1, 1'b1);
    put(ps_pkg::OP_NONE, 32'd0, 7'd0, 1'b0, 1'b0);
    put(ps_pkg::OP_TASK, 32'd0, 7'd0, 1'b0, 1'b1);
    put(ps_pkg::OP_LINK, 32'd5, 7'd127, 1'b1, 1'b1);
    put(ps_pkg::OP_LINK, 32'd10, 7'd0, 1'b0, 1'b0);
    put(ps_pkg::OP_LINK, 32'd20, 7'd0, 1'b1, 1'b1);
    put(ps_pkg::OP_TASK, 32'd999, 7'd100, 1'b0, 1'b0);
    put(ps_pkg::OP_TASK, 32'd1000, 7'd15, 1'b0, 1'b1);
    put(ps_pkg::OP_TASK, 32'd1500, 7'd0, 1'b0, 1'b0);
    put(ps_pkg::OP_TASK, 32'd1999, 7'd0, 1'b0, 1'b0);
    put(ps_pkg::OP_TASK, 32'd2000, 7'd16, 1'b0, 1'b0);
    put(ps_pkg::OP_TASK, 32'd3000, 7'd6, 1'b0, 1'b0);
    put(ps_pkg::OP_PRESS, 32'd3100, 7'd0, 1'b1, 1'b1);
    put(ps_pkg::OP_TASK, 32'd5099, 7'd127, 1'b1, 1'b0);
    put(ps_pkg::OP_TASK, 32'd5100, 7'd100, 1'b0, 1'b0);
    put(ps_pkg::OP_LINK, 32'd5200, 7'd0, 1'b0, 1'b0);
    put(ps_pkg::OP_TASK, 32'd305199, 7'd50, 1'b0, 1'b0);
    put(ps_pkg::OP_LINK, 32'd305300, 7'd0, 1'b0, 1'b1);
    put(ps_pkg::OP_TASK, 32'hFFFF_FFFF, 7'd64, 1'b0, 1'b1);
    put(ps_pkg::OP_PRESS, 32'hFFFF_FFF0, 7'd127, 1'b1, 1'b0);
    // The hold time wraps through zero and ends one short of the delay.
    put(ps_pkg::OP_TASK, 32'd1983, 7'd20, 1'b1, 1'b0);
    wait_idle();

    program_regs(32'($urandom_range(40, 1)), 7'd0, 7'($urandom_range(100, 20)),
                 32'hFFFF_FFFF, 32'($urandom_range(400, 100)), 1'b1);
    tick = 32'hFFFF_F000;
    random_items(200, 30, KEEP_ALL);
    wait_idle();

    program_regs(32'd0, 7'($urandom_range(20, 1)), 7'd127, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 1'b0);
    steady = 1'b1;
    random_items(150, 50, KEEP_ALL);
    steady = 1'b0;
    wait_idle();

    program_regs(32'hFFFF_FFFF, 7'($urandom_range(20)), 7'd0,
                 32'($urandom_range(2000, 200)), 32'($urandom_range(300, 1)), 1'b0);
    random_items(120, 40, KEEP_ALL);
    wait_idle();

    // Only one cause can be seen to cut power, so each run picks one at random.
    cause = cut_t'($urandom_range(2));
    final_keep = KEEP_ALL;
    final_keep[cause] = 1'b0;
    program_regs(32'($urandom_range(50)), (cause == CUT_BATTERY) ? 7'd127 : 7'd0,
                 7'($urandom_range(100)), (cause == CUT_LINK) ? 32'd0 : 32'hFFFF_FFFF,
                 (cause == CUT_HOLD) ? 32'd0 : 32'hFFFF_FFFF, 1'b0);
    random_items(60, 30, final_keep);
    wait_idle();

    program_regs(32'd0, 7'd127, 7'd127, 32'd0, 32'd0, 1'b0);
    random_items(60, 30, KEEP_NONE);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Checked %0d status results for %0d requests after %0d register writes.",
             results_seen, requests_sent, reg_writes);
    $display("Register settings ranged over both extremes; the power cut was aimed at %s.",
             cause.name());
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: power_off_supervisor.f
hdl/ps_pkg.sv
hdl/ps_if.sv
hdl/power_off_supervisor.sv
tb/sv/supervisor_monitor.sv
tb/sv/tb_power_off_supervisor.sv
